[hw/rtl/aenp_pkg.sv]
// Package for the ASCII number entry parser.
// Holds the character codes, command codes and the command word type.
// No dependencies; every other file imports it.
package aenp_pkg;

    // Widths fixed by the channel fields.
    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 16;
    localparam int ENTRY_W = 32;

    // Character codes that the parser reacts to.
    localparam logic [CHAR_W-1:0] CHAR_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_BS      = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_0       = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9       = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'h46;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_F = 8'h66;

    // Value of the letter A as a hexadecimal digit.
    localparam logic [CHAR_W-1:0] HEX_LETTER_BASE = 8'h0A;

    // The digit count stops here.
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // Command codes passed from the front to the back.
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_DIGIT = 2'd1;
    localparam logic [1:0] OP_BACK  = 2'd2;
    localparam logic [1:0] OP_ENTER = 2'd3;

    // One classified character.
    typedef struct packed {
        logic [1:0]        op;
        logic              hex;
        logic [3:0]        digit;
        logic [CHAR_W-1:0] ch;
    } cmd_t;

endpackage

[hw/rtl/aenp_front.sv]
// Front end of the ASCII number entry parser: classifies each received
// character into a command word for the back end.
// Depends on aenp_pkg.
module aenp_front
    import aenp_pkg::*;
(
    input  logic [CHAR_W-1:0] rx_char,
    input  logic              hex_mode,
    output cmd_t              cmd
);

    logic is_dec;
    logic is_upper;
    logic is_lower;

    // Character class decode.
    assign is_dec   = (rx_char >= CHAR_0) && (rx_char <= CHAR_9);
    assign is_upper = hex_mode && (rx_char >= CHAR_UPPER_A) && (rx_char <= CHAR_UPPER_F);
    assign is_lower = hex_mode && (rx_char >= CHAR_LOWER_A) && (rx_char <= CHAR_LOWER_F);

    // Build the command word.
    always_comb
    begin
        cmd.ch    = rx_char;
        cmd.hex   = hex_mode;
        cmd.digit = 4'd0;
        cmd.op    = OP_NONE;
        if (rx_char == CHAR_CR)
        begin
            cmd.op = OP_ENTER;
        end
        else if (is_dec)
        begin
            cmd.op    = OP_DIGIT;
            cmd.digit = 4'(rx_char - CHAR_0);
        end
        else if (is_upper)
        begin
            cmd.op    = OP_DIGIT;
            cmd.digit = 4'(rx_char - CHAR_UPPER_A + HEX_LETTER_BASE);
        end
        else if (is_lower)
        begin
            cmd.op    = OP_DIGIT;
            cmd.digit = 4'(rx_char - CHAR_LOWER_A + HEX_LETTER_BASE);
        end
        else if (rx_char == CHAR_BS)
        begin
            cmd.op = OP_BACK;
        end
    end

endmodule

[hw/rtl/aenp_queue.sv]
// Two-entry command queue between the front and back of the parser.
// Lets the input side keep accepting while the back end is busy.
// Depends on aenp_pkg.
module aenp_queue
    import aenp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int DEPTH = 2;

    cmd_t       slot_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'(DEPTH));
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[hw/rtl/aenp_back.sv]
// Back end of the ASCII number entry parser: holds the value and digit
// count, executes one command word per cycle while the output register is free
// and drives that register. Depends on aenp_pkg.
module aenp_back
    import aenp_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  cmd_t               cmd,
    output logic               cmd_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               echo_valid,
    output logic [CHAR_W-1:0]  echo_char,
    output logic               entry_done,
    output logic [ENTRY_W-1:0] entry_value
);

    localparam int EXT_W  = (VALUE_WIDTH > ENTRY_W) ? VALUE_WIDTH : ENTRY_W;
    localparam int PROD_W = 2 * VALUE_WIDTH;

    // Reciprocal of ten, rounded up and scaled by 2^(VALUE_WIDTH+3). The
    // product shifted down by VALUE_WIDTH+3 is the exact quotient for every
    // value of the accumulator.
    localparam logic [VALUE_WIDTH+3:0] DIV10_SCALE =
        (VALUE_WIDTH + 4)'(1) << (VALUE_WIDTH + 3);
    localparam logic [VALUE_WIDTH-1:0] DIV10_RECIP =
        VALUE_WIDTH'((DIV10_SCALE + (VALUE_WIDTH + 4)'(9)) / (VALUE_WIDTH + 4)'(10));

    logic [VALUE_WIDTH-1:0] acc_reg;
    logic [VALUE_WIDTH-1:0] acc_next;
    logic [COUNT_W-1:0]     count_reg;
    logic [COUNT_W-1:0]     count_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   echo_valid_reg;
    logic [CHAR_W-1:0]      echo_char_reg;
    logic                   entry_done_reg;
    logic [ENTRY_W-1:0]     entry_value_reg;

    logic                   out_free;
    logic                   load_out;
    logic                   o_echo;
    logic [CHAR_W-1:0]      o_char;
    logic                   o_done;
    logic [ENTRY_W-1:0]     o_value;
    logic [EXT_W-1:0]       acc_ext;
    logic [VALUE_WIDTH-1:0] hex_append;
    logic [VALUE_WIDTH-1:0] dec_append;
    logic [PROD_W-1:0]      div10_prod;
    logic [VALUE_WIDTH-1:0] dec_remove;
    logic [COUNT_W-1:0]     count_inc;

    // Datapath helpers.
    assign out_free   = !out_valid_reg || out_ready;
    assign acc_ext    = EXT_W'(acc_reg);
    assign hex_append = {acc_reg[VALUE_WIDTH-5:0], cmd.digit};
    assign dec_append = VALUE_WIDTH'({acc_reg, 3'b000}) + VALUE_WIDTH'({acc_reg, 1'b0})
                        + VALUE_WIDTH'(cmd.digit);
    assign div10_prod = PROD_W'(acc_reg) * PROD_W'(DIV10_RECIP);
    assign dec_remove = VALUE_WIDTH'(div10_prod[PROD_W-1:VALUE_WIDTH+3]);
    assign count_inc  = (count_reg == COUNT_MAX) ? count_reg : count_reg + 16'd1;

    // Command execution, one word per cycle while the output register is free.
    always_comb
    begin
        acc_next   = acc_reg;
        count_next = count_reg;
        cmd_pop    = 1'b0;
        load_out   = 1'b0;
        o_echo     = 1'b0;
        o_char     = '0;
        o_done     = 1'b0;
        o_value    = '0;
        if (cmd_valid && out_free)
        begin
            cmd_pop  = 1'b1;
            load_out = 1'b1;
            case (cmd.op)
                OP_ENTER:
                begin
                    o_done     = 1'b1;
                    o_value    = acc_ext[ENTRY_W-1:0];
                    acc_next   = '0;
                    count_next = '0;
                end
                OP_DIGIT:
                begin
                    o_echo     = 1'b1;
                    o_char     = cmd.ch;
                    acc_next   = cmd.hex ? hex_append : dec_append;
                    count_next = count_inc;
                end
                OP_BACK:
                begin
                    // A backspace with no digits entered still yields an output word, with no echo.
                    if (count_reg != '0)
                    begin
                        o_echo     = 1'b1;
                        o_char     = cmd.ch;
                        acc_next   = cmd.hex ? (acc_reg >> 4) : dec_remove;
                        count_next = count_reg - 16'd1;
                    end
                end
                default:
                begin
                    o_echo = 1'b0;
                end
            endcase
        end
    end

    // Output register handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            echo_valid_reg  <= o_echo;
            echo_char_reg   <= o_char;
            entry_done_reg  <= o_done;
            entry_value_reg <= o_value;
        end
    end

    assign out_valid   = out_valid_reg;
    assign echo_valid  = echo_valid_reg;
    assign echo_char   = echo_char_reg;
    assign entry_done  = entry_done_reg;
    assign entry_value = entry_value_reg;

endmodule

[hw/rtl/ascii_number_entry_parser_top.sv]
// Top level of the ASCII number entry parser.
// Depends on aenp_pkg, aenp_front, aenp_queue and aenp_back.
//
// Usage: one received character enters per word on the input channel
// (in_valid/in_ready, rx_char). Every input word yields exactly one output
// word (out_valid/out_ready) carrying echo_valid/echo_char for digits and
// accepted backspaces, and entry_done/entry_value when a carriage return
// closes an entry. cfg_wr_en/cfg_wr_data set the radix: 0 decimal, 1 hex.
//
// Flow: an accepted input word is written into the queue, then executed
// from its head into the output register. Every character, a decimal
// backspace included, executes combinationally (divide by ten by a reciprocal
// multiply), so words are taken at one per cycle while out_ready stays high.
//
// A two-word queue separates input from execution, so in_ready depends
// only on the queue fill and new words are taken while an output waits.
// When the receiver stalls, the output word holds and the queue fills,
// then in_ready drops until the cycle after the waiting word is taken.
// Reset clears the value, count, radix (decimal), queue and output valid.
module ascii_number_entry_parser_top
    import aenp_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CHAR_W-1:0]  rx_char,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               echo_valid,
    output logic [CHAR_W-1:0]  echo_char,
    output logic               entry_done,
    output logic [ENTRY_W-1:0] entry_value
);

    logic radix_mode_reg;
    logic radix_mode_next;
    cmd_t front_cmd;
    cmd_t head_cmd;
    logic queue_full;
    logic head_valid;
    logic cmd_pop;

    // Radix mode register.
    assign radix_mode_next = cfg_wr_en ? cfg_wr_data : radix_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_mode_reg <= 1'b0;
        end
        else
        begin
            radix_mode_reg <= radix_mode_next;
        end
    end

    assign in_ready = !queue_full;

    // Character classification.
    aenp_front u_front (
        .rx_char  (rx_char),
        .hex_mode (radix_mode_reg),
        .cmd      (front_cmd)
    );

    // Command queue.
    aenp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid && in_ready),
        .push_cmd   (front_cmd),
        .full       (queue_full),
        .pop        (cmd_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Execution and output register.
    aenp_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (head_valid),
        .cmd         (head_cmd),
        .cmd_pop     (cmd_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .echo_valid  (echo_valid),
        .echo_char   (echo_char),
        .entry_done  (entry_done),
        .entry_value (entry_value)
    );

endmodule

[hw/rtl/aenp_checker.sv]
// Port-level checker for the ASCII number entry parser, bound to the top.
// Depends on aenp_pkg and ascii_number_entry_parser_top.
module aenp_checker
    import aenp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic               echo_valid,
    input logic [CHAR_W-1:0]  echo_char,
    input logic               entry_done,
    input logic [ENTRY_W-1:0] entry_value
);

    // The output register is empty while reset is applied.
    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    // A stalled output word stays valid and keeps its echo character and entry value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(echo_char)
            && $stable(entry_value))
        else $error("stalled output word changed");

    // An echo and an entry end never share one word.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(echo_valid && entry_done))
        else $error("echo and entry end in one word");

    // Only digits and backspace are echoed; otherwise the echo field is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (echo_valid && (echo_char == CHAR_BS
            || (echo_char >= CHAR_0 && echo_char <= CHAR_9)
            || (echo_char >= CHAR_UPPER_A && echo_char <= CHAR_UPPER_F)
            || (echo_char >= CHAR_LOWER_A && echo_char <= CHAR_LOWER_F)))
            || (!echo_valid && echo_char == '0))
        else $error("bad echo field");

    // The value field is zero unless an entry ended.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !entry_done |-> entry_value == '0)
        else $error("value reported without entry end");

endmodule

bind ascii_number_entry_parser_top aenp_checker u_aenp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .echo_valid  (echo_valid),
    .echo_char   (echo_char),
    .entry_done  (entry_done),
    .entry_value (entry_value)
);

[sim/ascii_number_entry_parser_top_tb.sv]
// Self-checking testbench for ascii_number_entry_parser_top.
// A directed table and random character streams run against a built-in predictor.
// Depends on aenp_pkg and the parser RTL; reads no files.
module ascii_number_entry_parser_top_tb;
    import aenp_pkg::*;

    localparam int VALUE_W = 32;
    localparam logic RADIX_DEC = 1'b0;
    localparam logic RADIX_HEX = 1'b1;
    localparam logic [VALUE_W-1:0] DEC_BASE = 10;
    localparam logic [VALUE_W-1:0] HEX_BASE = 16;
    localparam int RANDOM_ITEMS = 1320;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int SETTLE_CYCLES = 40;

    // One output word of the parser.
    typedef struct packed {
        logic               echo_valid;
        logic [CHAR_W-1:0]  echo_char;
        logic               entry_done;
        logic [ENTRY_W-1:0] entry_value;
    } entry_result_t;

    localparam entry_result_t NO_RESULT = '0;

    typedef enum logic {ROW_CHAR, ROW_RADIX} row_kind_t;

    // One row of the directed table: a character or a radix write.
    typedef struct packed {
        row_kind_t     kind;
        logic [CHAR_W-1:0] ch;
        logic          radix;
        logic          has_typed;
        entry_result_t typed;
    } stim_row_t;

    logic               clk;
    logic               rst_n = 1'b1;
    logic               cfg_wr_en = 1'b0;
    logic               cfg_wr_data = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [CHAR_W-1:0]  rx_char = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               echo_valid;
    logic [CHAR_W-1:0]  echo_char;
    logic               entry_done;
    logic [ENTRY_W-1:0] entry_value;

    // Predictor state, mirroring the parser registers.
    logic               shadow_hex = RADIX_DEC;
    logic [VALUE_W-1:0] shadow_value = '0;
    logic [COUNT_W-1:0] shadow_count = '0;

    entry_result_t pending_results[$];
    entry_result_t oldest_result;
    entry_result_t seen_result;
    stim_row_t     directed_rows[$];
    int            mismatch_count = 0;
    int            effective_items = 0;
    int            burst_left = 1;
    int            idle_cycles = 0;
    int            stall_mode = 0;
    int            mode_left = 0;
    int            stall_phase = 0;

    ascii_number_entry_parser_top #(
        .VALUE_WIDTH (VALUE_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_char     (rx_char),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .echo_valid  (echo_valid),
        .echo_char   (echo_char),
        .entry_done  (entry_done),
        .entry_value (entry_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Applies one character to the predictor state and returns the word it should produce.
    function automatic entry_result_t predict_entry(input logic [CHAR_W-1:0] ch);
        entry_result_t      res;
        logic [VALUE_W-1:0] base;
        logic [CHAR_W-1:0]  offset;
        logic               is_digit;
        res = '0;
        base = shadow_hex ? HEX_BASE : DEC_BASE;
        is_digit = 1'b1;
        if (ch >= CHAR_0 && ch <= CHAR_9)
            offset = ch - CHAR_0;
        else if (shadow_hex && ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_F)
            offset = ch - CHAR_UPPER_A + HEX_LETTER_BASE;
        else if (shadow_hex && ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_F)
            offset = ch - CHAR_LOWER_A + HEX_LETTER_BASE;
        else
        begin
            offset = '0;
            is_digit = 1'b0;
        end

        if (ch == CHAR_CR)
        begin
            res.entry_done = 1'b1;
            res.entry_value = shadow_value[ENTRY_W-1:0];
            shadow_value = '0;
            shadow_count = '0;
        end
        else if (is_digit)
        begin
            // The product wraps at the value width.
            shadow_value = shadow_value * base + offset[3:0];
            if (shadow_count != COUNT_MAX)
                shadow_count = shadow_count + 1'b1;
            res.echo_valid = 1'b1;
            res.echo_char = ch;
        end
        else if (ch == CHAR_BS && shadow_count != '0)
        begin
            shadow_value = shadow_value / base;
            shadow_count = shadow_count - 1'b1;
            res.echo_valid = 1'b1;
            res.echo_char = ch;
        end
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] random_digit(input logic hex);
        int v;
        v = hex ? $urandom_range(0, 15) : $urandom_range(0, 9);
        if (v < 10)
            return CHAR_W'(CHAR_0 + v);
        return CHAR_W'(($urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_LOWER_A) + v - 10);
    endfunction

    function automatic stim_row_t make_char_row(input logic [CHAR_W-1:0] ch);
        stim_row_t row;
        row = '0;
        row.kind = ROW_CHAR;
        row.ch = ch;
        return row;
    endfunction

    function automatic stim_row_t make_typed_row(input logic [CHAR_W-1:0] ch, input logic ev,
                                                 input logic [CHAR_W-1:0] ec, input logic ed,
                                                 input logic [ENTRY_W-1:0] val);
        stim_row_t row;
        row = make_char_row(ch);
        row.has_typed = 1'b1;
        row.typed.echo_valid = ev;
        row.typed.echo_char = ec;
        row.typed.entry_done = ed;
        row.typed.entry_value = val;
        return row;
    endfunction

    function automatic stim_row_t make_radix_row(input logic radix);
        stim_row_t row;
        row = '0;
        row.kind = ROW_RADIX;
        row.radix = radix;
        return row;
    endfunction

    // Sends one character word; called at a falling edge and returns at one.
    // The valid stays high into the next word unless the burst ends here.
    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic has_typed,
                             input entry_result_t typed);
        entry_result_t predicted;
        rx_char <= ch;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = predict_entry(ch);
        effective_items++;
        pending_results.push_back(has_typed ? typed : predicted);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Drops a valid left high at the end of a burst; called at a falling edge.
    task automatic release_input();
        if (in_valid)
            in_valid <= 1'b0;
    endtask

    task automatic wait_for_results_drained();
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // The radix register is written only with no word in flight.
    task automatic set_radix_mode(input logic mode);
        release_input();
        wait_for_results_drained();
        cfg_wr_data <= mode;
        cfg_wr_en <= 1'b1;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        shadow_hex = mode;
        @(negedge clk);
    endtask

    task automatic report_mismatch(input string field, input logic [ENTRY_W-1:0] want,
                                   input logic [ENTRY_W-1:0] got);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endtask

    // Compare each accepted output word with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_result = {echo_valid, echo_char, entry_done, entry_value};
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected output word, expected none, actual %h",
                         $time, seen_result);
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (seen_result.echo_valid !== oldest_result.echo_valid)
                    report_mismatch("echo_valid", ENTRY_W'(oldest_result.echo_valid),
                                    ENTRY_W'(seen_result.echo_valid));
                if (seen_result.echo_char !== oldest_result.echo_char)
                    report_mismatch("echo_char", ENTRY_W'(oldest_result.echo_char),
                                    ENTRY_W'(seen_result.echo_char));
                if (seen_result.entry_done !== oldest_result.entry_done)
                    report_mismatch("entry_done", ENTRY_W'(oldest_result.entry_done),
                                    ENTRY_W'(seen_result.entry_done));
                if (seen_result.entry_value !== oldest_result.entry_value)
                    report_mismatch("entry_value", oldest_result.entry_value,
                                    seen_result.entry_value);
            end
        end
    end

    // Receiver backpressure: switches between always ready, random stalls,
    // a fixed two-of-five pattern and a sparse one-of-eight pattern.
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 7);
            mode_left = $urandom_range(20, 300);
        end
        else
            mode_left--;
        stall_phase++;
        if (stall_mode < 3)
            out_ready <= 1'b1;
        else if (stall_mode < 5)
            out_ready <= ($urandom_range(0, 3) != 0);
        else if (stall_mode < 7)
            out_ready <= (stall_phase % 5) < 2;
        else
            out_ready <= (stall_phase % 8) == 0;
    end

    // Watchdog on cycles in which no word moves on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int steps;
        int pick;
        logic [CHAR_W-1:0] ch;

        // Reset goes low with an edge so the asynchronous reset takes hold.
        rst_n <= 1'b0;

        // Directed table: extremes, ignored characters, backspace rules and a
        // radix switch in the middle of an entry.
        directed_rows.push_back(make_radix_row(RADIX_DEC));
        directed_rows.push_back(make_typed_row(CHAR_CR, 1'b0, 8'h00, 1'b1, 32'h0));
        directed_rows.push_back(make_typed_row(CHAR_BS, 1'b0, 8'h00, 1'b0, 32'h0));
        directed_rows.push_back(make_typed_row(8'h00, 1'b0, 8'h00, 1'b0, 32'h0));
        directed_rows.push_back(make_typed_row(8'hFF, 1'b0, 8'h00, 1'b0, 32'h0));
        directed_rows.push_back(make_typed_row("a", 1'b0, 8'h00, 1'b0, 32'h0));
        directed_rows.push_back(make_typed_row("F", 1'b0, 8'h00, 1'b0, 32'h0));
        directed_rows.push_back(make_typed_row("9", 1'b1, "9", 1'b0, 32'h0));
        directed_rows.push_back(make_typed_row("0", 1'b1, "0", 1'b0, 32'h0));
        directed_rows.push_back(make_typed_row(CHAR_BS, 1'b1, CHAR_BS, 1'b0, 32'h0));
        directed_rows.push_back(make_radix_row(RADIX_HEX));
        directed_rows.push_back(make_char_row("f"));
        directed_rows.push_back(make_char_row("A"));
        directed_rows.push_back(make_char_row(CHAR_BS));
        directed_rows.push_back(make_char_row("g"));
        directed_rows.push_back(make_char_row(CHAR_CR));
        repeat (9)
            directed_rows.push_back(make_typed_row("F", 1'b1, "F", 1'b0, 32'h0));
        directed_rows.push_back(make_typed_row(CHAR_CR, 1'b0, 8'h00, 1'b1, 32'hFFFF_FFFF));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_RADIX)
                set_radix_mode(directed_rows[i].radix);
            else
                send_char(directed_rows[i].ch, directed_rows[i].has_typed,
                          directed_rows[i].typed);
        end

        // Random entries: mostly digits with backspaces mixed in, some noise,
        // letters of either case, radix switches and a few missing returns.
        effective_items = 0;
        while (effective_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
                set_radix_mode(1'($urandom_range(0, 1)));
            steps = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 10);
            for (int k = 0; k < steps; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 68)
                    ch = random_digit(shadow_hex);
                else if (pick < 84)
                    ch = CHAR_BS;
                else if (pick < 94)
                    ch = CHAR_W'($urandom_range(0, 255));
                else
                    ch = CHAR_W'(($urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_LOWER_A)
                                 + $urandom_range(0, 25));
                if (pick >= 98)
                    set_radix_mode(!shadow_hex);
                else
                    send_char(ch, 1'b0, NO_RESULT);
            end
            if ($urandom_range(0, 15) != 0)
                send_char(CHAR_CR, 1'b0, NO_RESULT);
        end

        release_input();
        wait_for_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
